// File: rtl/core/rfi_pkg.sv
// Package for the random fault injector: payload types, register indexes and constants.
package rfi_pkg;

    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_INJECT_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FAIL_ONE_IN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IGNORE_FIRST  = 2'd2;

    localparam logic [31:0] RST_FAIL_ONE_IN = 32'd1000;

    localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01B3;
    localparam logic [63:0] SM_GAMMA  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] SM_MUL1   = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] SM_MUL2   = 64'h94D0_49BB_1331_11EB;

    typedef struct packed {
        logic       kind;
        logic [7:0] seed_byte;
        logic       seed_last;
        logic       caller_allowlisted;
    } t_in_item;

    typedef struct packed {
        logic        fail;
        logic        random_hit;
        logic [63:0] request_number;
    } t_out_item;

endpackage

// File: rtl/core/rfi_mul64.sv
// Iterative 64x64 low-half multiplier built on one shared 32x32 multiplier.
module rfi_mul64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_op_x;
    logic [31:0] w_op_y;
    logic [63:0] w_pp;

    always_comb begin
        case (r_step)
            2'd0: begin
                w_op_x = r_a[31:0];
                w_op_y = r_b[31:0];
            end
            2'd1: begin
                w_op_x = r_a[31:0];
                w_op_y = r_b[63:32];
            end
            default: begin
                w_op_x = r_a[63:32];
                w_op_y = r_b[31:0];
            end
        endcase
    end

    assign w_pp = {32'd0, w_op_x} * {32'd0, w_op_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            case (r_step)
                2'd0: r_prod <= w_pp;
                2'd1: begin
                    r_acc  <= r_prod;
                    r_prod <= w_pp;
                end
                2'd2: begin
                    r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                    r_prod       <= w_pp;
                end
                default: r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: rtl/core/rfi_mod64.sv
// Bit-serial restoring remainder of a 64-bit dividend by a nonzero 32-bit divisor.
module rfi_mod64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_rem
);
    logic [63:0] r_dvd;
    logic [31:0] r_dvs;
    logic [31:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_trial;
    logic [33:0] w_sub;

    assign w_trial = {r_rem, r_dvd[63]};
    assign w_sub   = {1'b0, w_trial} - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= 32'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[62:0], 1'b0};
            r_rem <= w_sub[33] ? w_trial[31:0] : w_sub[31:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: rtl/core/random_fault_injector_top.sv
// Random fault injector top level: sequencer, state registers and output register.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, payload i_in_data) carries seed bytes
//   and allocation requests. Output channel (o_out_valid / i_out_stall, payload
//   o_out_data) carries one decision per counted request.
//   Seed bytes fold into an FNV-1a hash through the shared multiplier and give
//   no output. The byte flagged last loads the hash into the random state.
//   Requests while injection is disabled give no output.
//   Requests inside the ignore window skip the draw and report no hit.
//   Other requests step splitmix64: two 64-bit multiplies on the one 32x32
//   multiplier, then a bit-serial remainder unless the divisor is zero, in which
//   case a hit needs a zero draw. One item is worked on at a time; o_in_stall
//   is high while it runs.
//   The result sits in an output register; a stalled receiver holds it, and a
//   finished decision waits until that register frees up.
//   Reset (synchronous, active low) restores configuration registers to defaults,
//   clears the random state and counters and reloads the FNV offset basis.
//   Configuration writes take effect at once and belong to idle periods.
module random_fault_injector_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  rfi_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output rfi_pkg::t_out_item           o_out_data,
    input  logic                         i_cfg_we,
    input  logic [rfi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rfi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rfi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_MIX_GO,
        S_MIX1,
        S_MIX2,
        S_MOD,
        S_FIN
    } t_state;

    t_state      r_state;
    logic        r_enable;
    logic [31:0] r_fail_one_in;
    logic [31:0] r_ignore_first;
    logic [63:0] r_rand;
    logic [63:0] r_hash;
    logic [63:0] r_req_total;
    logic [31:0] r_skipped;
    logic        r_last;
    logic        r_allow;
    logic        r_res_hit;
    logic        r_out_valid;
    t_out_item   r_out_data;

    logic        w_in_xfer;
    logic        w_mul_start;
    logic [63:0] w_mul_a;
    logic [63:0] w_mul_b;
    logic        w_mul_done;
    logic [63:0] w_mul_prod;
    logic [63:0] w_draw;
    logic        w_mod_start;
    logic        w_mod_done;
    logic [31:0] w_mod_rem;
    logic        w_out_free;

    assign w_in_xfer  = i_in_valid && (r_state == S_IDLE);
    assign w_draw     = w_mul_prod ^ (w_mul_prod >> 31);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = 64'd0;
        w_mul_b     = 64'd0;
        case (r_state)
            S_IDLE: begin
                w_mul_start = w_in_xfer && i_in_data.kind;
                w_mul_a     = r_hash ^ {56'd0, i_in_data.seed_byte};
                w_mul_b     = FNV_PRIME;
            end
            S_MIX_GO: begin
                w_mul_start = 1'b1;
                w_mul_a     = r_rand ^ (r_rand >> 30);
                w_mul_b     = SM_MUL1;
            end
            S_MIX1: begin
                w_mul_start = w_mul_done;
                w_mul_a     = w_mul_prod ^ (w_mul_prod >> 27);
                w_mul_b     = SM_MUL2;
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    assign w_mod_start = (r_state == S_MIX2) && w_mul_done && (r_fail_one_in != 32'd0);

    rfi_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    rfi_mod64 u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_draw),
        .i_divisor  (r_fail_one_in),
        .o_done     (w_mod_done),
        .o_rem      (w_mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_enable       <= 1'b1;
            r_fail_one_in  <= RST_FAIL_ONE_IN;
            r_ignore_first <= 32'd0;
            r_rand         <= 64'd0;
            r_hash         <= FNV_BASIS;
            r_req_total    <= 64'd0;
            r_skipped      <= 32'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if ((r_state == S_FIN) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_INJECT_ENABLE: r_enable       <= i_cfg_data[0];
                    REG_FAIL_ONE_IN:   r_fail_one_in  <= i_cfg_data;
                    REG_IGNORE_FIRST:  r_ignore_first <= i_cfg_data;
                    default:           ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_last  <= i_in_data.seed_last;
                        r_allow <= i_in_data.caller_allowlisted;
                        if (i_in_data.kind) begin
                            r_state <= S_SEED;
                        end else if (r_enable) begin
                            r_req_total <= r_req_total + 64'd1;
                            if (r_skipped < r_ignore_first) begin
                                r_skipped <= r_skipped + 32'd1;
                                r_res_hit <= 1'b0;
                                r_state   <= S_FIN;
                            end else begin
                                r_rand  <= r_rand + SM_GAMMA;
                                r_state <= S_MIX_GO;
                            end
                        end
                    end
                end
                S_SEED: begin
                    if (w_mul_done) begin
                        if (r_last) begin
                            r_rand <= w_mul_prod;
                            r_hash <= FNV_BASIS;
                        end else begin
                            r_hash <= w_mul_prod;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_MIX_GO: begin
                    r_state <= S_MIX1;
                end
                S_MIX1: begin
                    if (w_mul_done) begin
                        r_state <= S_MIX2;
                    end
                end
                S_MIX2: begin
                    if (w_mul_done) begin
                        if (r_fail_one_in == 32'd0) begin
                            r_res_hit <= (w_draw == 64'd0);
                            r_state   <= S_FIN;
                        end else begin
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_res_hit <= (w_mod_rem == 32'd0);
                        r_state   <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_data.fail            <= r_res_hit && !r_allow;
                        r_out_data.random_hit      <= r_res_hit;
                        r_out_data.request_number  <= r_req_total;
                        r_state                    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef SYNTHESIS
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_FIN))
        else $error("output became valid outside the finish state");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_SEED || r_state == S_MIX1 || r_state == S_MIX2))
        else $error("multiplier finished while the sequencer was not waiting");

    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder unit finished while the sequencer was not waiting");

    a_seed_goes_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_in_data.kind) |=> (r_state == S_SEED))
        else $error("seed byte transfer did not start a hash step");
`endif

endmodule

// File: verif/random_fault_injector_top_tb.sv
// Testbench for random_fault_injector_top: seed/request traffic against a decision predictor.
module random_fault_injector_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rfi_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned ITEMS_PER_PHASE = 145;
    localparam int unsigned NUM_PHASES = 10;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    class fault_decision_board;
        bit          inject_on;
        bit [31:0]   one_in;
        bit [31:0]   skip_limit;
        bit [63:0]   rng_state;
        bit [63:0]   fnv_acc;
        bit [63:0]   req_count;
        bit [31:0]   skips;
        t_out_item   decisions_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            inject_on = 1'b1;
            one_in = RST_FAIL_ONE_IN;
            skip_limit = '0;
            rng_state = '0;
            fnv_acc = FNV_BASIS;
            req_count = '0;
            skips = '0;
            decisions_q.delete();
        endfunction

        function int pending();
            return decisions_q.size();
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_INJECT_ENABLE: inject_on = val[0];
                REG_FAIL_ONE_IN:   one_in = val;
                REG_IGNORE_FIRST:  skip_limit = val;
                default: ;
            endcase
        endfunction

        function bit [63:0] splitmix_next();
            bit [63:0] z;
            rng_state = rng_state + SM_GAMMA;
            z = rng_state;
            z = (z ^ (z >> 30)) * SM_MUL1;
            z = (z ^ (z >> 27)) * SM_MUL2;
            return z ^ (z >> 31);
        endfunction

        function void note_transfer(t_in_item it);
            bit [63:0] draw;
            bit [63:0] rem;
            bit        hit;
            t_out_item d;
            if (it.kind) begin
                fnv_acc = (fnv_acc ^ {56'd0, it.seed_byte}) * FNV_PRIME;
                if (it.seed_last) begin
                    rng_state = fnv_acc;
                    fnv_acc = FNV_BASIS;
                end
                return;
            end
            if (!inject_on)
                return;
            req_count = req_count + 64'd1;
            if (skips < skip_limit) begin
                skips = skips + 32'd1;
                d.fail = 1'b0;
                d.random_hit = 1'b0;
                d.request_number = req_count;
                decisions_q.push_back(d);
                return;
            end
            draw = splitmix_next();
            rem = (one_in != 0) ? (draw % {32'd0, one_in}) : draw;
            hit = (rem == 64'd0);
            d.fail = hit && !it.caller_allowlisted;
            d.random_hit = hit;
            d.request_number = req_count;
            decisions_q.push_back(d);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (decisions_q.size() == 0) begin
                report_mismatch($sformatf("unexpected decision for request %0d",
                    got.request_number));
                return;
            end
            want = decisions_q.pop_front();
            if (got.fail !== want.fail)
                report_mismatch($sformatf("request %0d fail want %0b got %0b",
                    want.request_number, want.fail, got.fail));
            if (got.random_hit !== want.random_hit)
                report_mismatch($sformatf("request %0d random_hit want %0b got %0b",
                    want.request_number, want.random_hit, got.random_hit));
            if (got.request_number !== want.request_number)
                report_mismatch($sformatf("request_number want %0d got %0d",
                    want.request_number, got.request_number));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fault_decision_board sb;
    bit                  idle_on;
    int unsigned         counted;
    int unsigned         cycle_count;

    random_fault_injector_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item mk_item(bit kind, bit [7:0] b, bit last, bit allow);
        t_in_item it;
        it.kind = kind;
        it.seed_byte = b;
        it.seed_last = last;
        it.caller_allowlisted = allow;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int unsigned gap;
        gap = (idle_on && $urandom_range(0, 99) >= 55) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_transfer(it);
        counted++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] en_w, logic [31:0] div_w, logic [31:0] ign_w,
                             bit poke_unused);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_INJECT_ENABLE;
        i_cfg_data <= en_w;
        sb.write_reg(REG_INJECT_ENABLE, en_w);
        @(negedge i_clk);
        i_cfg_addr <= REG_FAIL_ONE_IN;
        i_cfg_data <= div_w;
        sb.write_reg(REG_FAIL_ONE_IN, div_w);
        @(negedge i_clk);
        i_cfg_addr <= REG_IGNORE_FIRST;
        i_cfg_data <= ign_w;
        sb.write_reg(REG_IGNORE_FIRST, ign_w);
        if (poke_unused) begin
            @(negedge i_clk);
            i_cfg_addr <= REG_UNUSED;
            i_cfg_data <= $urandom;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_traffic(int unsigned target);
        int unsigned r;
        int unsigned n;
        counted = 0;
        while (counted < target) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 59) == 0)
                drain();
            if (r < 20) begin
                n = $urandom_range(1, 8);
                for (int i = 1; i <= n; i++)
                    send_item(mk_item(1'b1, 8'($urandom), i == n, 1'($urandom)));
            end else if (r < 85) begin
                n = $urandom_range(1, 6);
                repeat (n)
                    send_item(mk_item(1'b0, 8'($urandom), 1'($urandom),
                                      $urandom_range(0, 3) == 0));
            end else begin
                send_item(mk_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
            end
        end
    endtask

    // output side: random stall runs, always sampled at the rising edge
    initial begin
        int unsigned run_left;
        bit          stalling;
        run_left = 0;
        stalling = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (run_left == 0) begin
                stalling = idle_on && ($urandom_range(0, 2) == 0);
                run_left = stalling ? idle_len() : $urandom_range(1, 20);
            end
            run_left--;
            i_out_stall <= stalling;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_data);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [31:0] en_w;
        logic [31:0] div_w;
        logic [31:0] ign_w;
        int unsigned w;
        sb = new();
        idle_on = 1'b1;
        counted = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, seed extremes
        send_item(mk_item(1'b1, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b1, 8'hFF, 1'b1, 1'b1));
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'hFF, 1'b1, 1'b1));

        // every draw hits; first two requests sit in the ignore window
        configure(32'h0000_0001, 32'd1, 32'd2, 1'b0);
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b1));
        send_item(mk_item(1'b0, 8'h5A, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'hA5, 1'b1, 1'b1));

        // injection off: requests vanish, seeding still works
        configure(32'hFFFF_FFFE, 32'd1, 32'd0, 1'b0);
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'hFF, 1'b1, 1'b1));
        send_item(mk_item(1'b1, 8'hA5, 1'b1, 1'b0));

        // zero divisor, plus a write to an unmapped index
        configure(32'h0000_0001, 32'd0, 32'd0, 1'b1);
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b1));

        // widest divisor; ignore window at its limit
        configure(32'h8000_0001, 32'hFFFF_FFFF, 32'd0, 1'b0);
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b1));
        configure(32'h0000_0001, 32'd2, 32'hFFFF_FFFF, 1'b0);
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b0));
        send_item(mk_item(1'b0, 8'h00, 1'b0, 1'b1));

        for (int p = 0; p < NUM_PHASES; p++) begin
            en_w = $urandom;
            en_w[0] = (p != 4);
            case (p)
                0: div_w = 32'd2;
                1: div_w = 32'd7;
                2: div_w = 32'd1;
                3: div_w = 32'hFFFF_FFFF;
                4: div_w = $urandom_range(1, 16);
                5: div_w = 32'd1000;
                6: div_w = 32'd0;
                7: div_w = 32'd5;
                8: div_w = $urandom;
                default: div_w = $urandom_range(1, 8);
            endcase
            case (p)
                2: ign_w = 32'hFFFF_FFFF;
                3: ign_w = 32'd0;
                5: ign_w = sb.skips + 32'd20;
                default: ign_w = $urandom_range(0, 1) ? 32'd0 : sb.skips + $urandom_range(0, 8);
            endcase
            idle_on = !(p == 1 || p == 7);
            configure(en_w, div_w, ign_w, p == 8);
            random_traffic(ITEMS_PER_PHASE);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        w = 0;
        while (sb.pending() != 0 && w < 50_000) begin
            @(posedge i_clk);
            w++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d decisions never arrived", sb.pending()));

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
